// ----- rtl/nsqb_pkg.sv -----
// Shared constants, codes and control types for the named stack/queue bank.
package nsqb_pkg;

  localparam int MAX_LISTS  = 16;
  localparam int LIST_DEPTH = 64;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W    = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int PTR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int MEM_DEPTH = MAX_LISTS * LIST_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  localparam logic KIND_STACK = 1'b0;
  localparam logic KIND_QUEUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL  = 3'd5;

  // Step strobes from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
    logic finish;
  } ctl_t;

endpackage

// ----- rtl/nsqb_ifs.sv -----
// Valid/ready channel interfaces for command words and result words.
interface nsqb_in_if;
  logic                               valid;
  logic                               ready;
  logic        [nsqb_pkg::CMD_W-1:0]  cmd;
  logic        [nsqb_pkg::KEY_W-1:0]  list_name;
  logic                               kind;
  logic signed [nsqb_pkg::DATA_W-1:0] value;

  modport source (output valid, cmd, list_name, kind, value, input ready);
  modport sink (input valid, cmd, list_name, kind, value, output ready);
endinterface

interface nsqb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [nsqb_pkg::STATUS_W-1:0] status;
  logic signed [nsqb_pkg::DATA_W-1:0]   popped_value;
  logic                                 popped_valid;

  modport source (output valid, status, popped_value, popped_valid, input ready);
  modport sink (input valid, status, popped_value, popped_valid, output ready);
endinterface

// ----- rtl/nsqb_ctrl.sv -----
// Sequencer for the bank: capture, table lookup, execute, result hand-off.
module nsqb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output nsqb_pkg::ctl_t   ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    ctl.capture = 1'b0;
    ctl.lookup  = 1'b0;
    ctl.execute = 1'b0;
    ctl.finish  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.lookup = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        ctl.execute = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // Wait here until the result register can take the new word.
        if (out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/nsqb_datapath.sv -----
// List table, element storage and result registers of the bank.
module nsqb_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nsqb_pkg::ctl_t                   ctl,
  input  logic [nsqb_pkg::CMD_W-1:0]       in_cmd,
  input  logic [nsqb_pkg::KEY_W-1:0]       in_list_name,
  input  logic                             in_kind,
  input  logic [nsqb_pkg::DATA_W-1:0]      in_value,
  output logic [nsqb_pkg::STATUS_W-1:0]    out_status,
  output logic [nsqb_pkg::DATA_W-1:0]      out_popped_value,
  output logic                             out_popped_valid
);

  // Captured command word.
  logic [nsqb_pkg::CMD_W-1:0]      cmd_r;
  logic [nsqb_pkg::KEY_W-1:0]      key_r;
  logic                            kind_r;
  logic [nsqb_pkg::DATA_W-1:0]     value_r;

  // List table.
  logic                            entry_valid_r [nsqb_pkg::MAX_LISTS];
  logic [nsqb_pkg::KEY_W-1:0]      entry_key_r   [nsqb_pkg::MAX_LISTS];
  logic                            entry_kind_r  [nsqb_pkg::MAX_LISTS];
  logic [nsqb_pkg::PTR_W-1:0]      entry_head_r  [nsqb_pkg::MAX_LISTS];
  logic [nsqb_pkg::CNT_W-1:0]      entry_count_r [nsqb_pkg::MAX_LISTS];

  // Element storage.
  logic [nsqb_pkg::VALUE_BITS-1:0] mem [nsqb_pkg::MEM_DEPTH];
  logic [nsqb_pkg::VALUE_BITS-1:0] rdata_r;

  // Lookup results.
  logic                            hit_r, hit_nxt;
  logic [nsqb_pkg::SLOT_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic                            free_r, free_nxt;
  logic [nsqb_pkg::SLOT_W-1:0]     free_slot_r, free_slot_nxt;

  // Execute results.
  logic [nsqb_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                            pop_ok_r, pop_ok_nxt;

  logic [nsqb_pkg::STATUS_W-1:0]   out_status_r;
  logic [nsqb_pkg::DATA_W-1:0]     out_value_r;
  logic                            out_pvalid_r;

  // Execute-step controls.
  logic                            mem_we, mem_re;
  logic [nsqb_pkg::PTR_W-1:0]      pos;
  logic [nsqb_pkg::ADDR_W-1:0]     mem_addr;
  logic                            tbl_create, tbl_push, tbl_pop;
  logic [nsqb_pkg::PTR_W-1:0]      cur_head, head_nxt;
  logic [nsqb_pkg::CNT_W-1:0]      cur_count;
  logic                            cur_kind;
  logic [nsqb_pkg::SUM_W-1:0]      tail_sum;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_cmd;
      key_r   <= in_list_name;
      kind_r  <= in_kind;
      value_r <= in_value;
    end
  end

  // Parallel key match and lowest free slot; the lowest index wins.
  always_comb begin
    hit_nxt       = 1'b0;
    hit_slot_nxt  = '0;
    free_nxt      = 1'b0;
    free_slot_nxt = '0;
    for (int i = nsqb_pkg::MAX_LISTS - 1; i >= 0; i--) begin
      if (entry_valid_r[i] && (entry_key_r[i] == key_r)) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = nsqb_pkg::SLOT_W'(i);
      end
      if (!entry_valid_r[i]) begin
        free_nxt      = 1'b1;
        free_slot_nxt = nsqb_pkg::SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      hit_r       <= hit_nxt;
      hit_slot_r  <= hit_slot_nxt;
      free_r      <= free_nxt;
      free_slot_r <= free_slot_nxt;
    end
  end

  assign cur_head  = entry_head_r[hit_slot_r];
  assign cur_count = entry_count_r[hit_slot_r];
  assign cur_kind  = entry_kind_r[hit_slot_r];
  assign tail_sum  = nsqb_pkg::SUM_W'(cur_head) + nsqb_pkg::SUM_W'(cur_count);

  always_comb begin
    status_nxt = nsqb_pkg::ST_OK;
    pop_ok_nxt = 1'b0;
    tbl_create = 1'b0;
    tbl_push   = 1'b0;
    tbl_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    pos        = cur_head;
    head_nxt   = cur_head;
    case (cmd_r)
      nsqb_pkg::CMD_CREATE: begin
        if (hit_r) begin
          status_nxt = nsqb_pkg::ST_EXISTS;
        end else if (!free_r) begin
          status_nxt = nsqb_pkg::ST_TABLE_FULL;
        end else begin
          tbl_create = 1'b1;
        end
      end
      nsqb_pkg::CMD_PUSH: begin
        if (!hit_r) begin
          status_nxt = nsqb_pkg::ST_UNKNOWN;
        end else if (cur_count == nsqb_pkg::CNT_W'(nsqb_pkg::LIST_DEPTH)) begin
          status_nxt = nsqb_pkg::ST_LIST_FULL;
        end else begin
          tbl_push = 1'b1;
          mem_we   = 1'b1;
          if (cur_kind == nsqb_pkg::KIND_QUEUE) begin
            // Tail slot: head plus count, wrapped once around the ring.
            if (tail_sum >= nsqb_pkg::SUM_W'(nsqb_pkg::LIST_DEPTH)) begin
              pos = nsqb_pkg::PTR_W'(tail_sum - nsqb_pkg::SUM_W'(nsqb_pkg::LIST_DEPTH));
            end else begin
              pos = nsqb_pkg::PTR_W'(tail_sum);
            end
          end else begin
            // A stack grows downward from its head.
            if (cur_head == '0) begin
              pos = nsqb_pkg::PTR_W'(nsqb_pkg::LIST_DEPTH - 1);
            end else begin
              pos = cur_head - nsqb_pkg::PTR_W'(1);
            end
            head_nxt = pos;
          end
        end
      end
      nsqb_pkg::CMD_POP: begin
        if (!hit_r) begin
          status_nxt = nsqb_pkg::ST_UNKNOWN;
        end else if (cur_count == '0) begin
          status_nxt = nsqb_pkg::ST_EMPTY;
        end else begin
          tbl_pop    = 1'b1;
          mem_re     = 1'b1;
          pop_ok_nxt = 1'b1;
          if (cur_head == nsqb_pkg::PTR_W'(nsqb_pkg::LIST_DEPTH - 1)) begin
            head_nxt = '0;
          end else begin
            head_nxt = cur_head + nsqb_pkg::PTR_W'(1);
          end
        end
      end
      default: status_nxt = nsqb_pkg::ST_OK;
    endcase
  end

  assign mem_addr = nsqb_pkg::ADDR_W'(hit_slot_r) * nsqb_pkg::ADDR_W'(nsqb_pkg::LIST_DEPTH)
                    + nsqb_pkg::ADDR_W'(pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nsqb_pkg::MAX_LISTS; i++) begin
        entry_valid_r[i] <= 1'b0;
        entry_head_r[i]  <= '0;
        entry_count_r[i] <= '0;
      end
    end else if (ctl.execute) begin
      if (tbl_create) begin
        entry_valid_r[free_slot_r] <= 1'b1;
        entry_head_r[free_slot_r]  <= '0;
        entry_count_r[free_slot_r] <= '0;
      end
      if (tbl_push) begin
        entry_head_r[hit_slot_r]  <= head_nxt;
        entry_count_r[hit_slot_r] <= cur_count + nsqb_pkg::CNT_W'(1);
      end
      if (tbl_pop) begin
        entry_head_r[hit_slot_r]  <= head_nxt;
        entry_count_r[hit_slot_r] <= cur_count - nsqb_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute && tbl_create) begin
      entry_key_r[free_slot_r]  <= key_r;
      entry_kind_r[free_slot_r] <= kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute && mem_we) begin
      mem[mem_addr] <= nsqb_pkg::VALUE_BITS'(value_r);
    end
    if (ctl.execute && mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_status_r <= status_r;
      out_pvalid_r <= pop_ok_r;
      out_value_r  <= pop_ok_r ? nsqb_pkg::DATA_W'(rdata_r) : '0;
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_value_r;
  assign out_popped_valid = out_pvalid_r;

endmodule

// ----- rtl/named_stack_queue_bank.sv -----
// Top level of the named stack/queue bank: channels, sequencer and datapath.
//
// Each command word creates a named list (a stack or a queue), pushes a value
// onto a list or pops one off it, and yields exactly one result word carrying
// a status code and, for a successful pop, the removed element. The table
// holds 16 lists keyed by 32-bit names; each list owns a fixed ring of 64
// elements in a single-port storage array. Every command runs through these
// steps, the accepting one included: the accepting step captures the word,
// then come the parallel name match and free-slot search over the table,
// the table update and the single storage access, and the loading of the
// result. The storage port, touched once per command, and the lookup that
// must precede it set this sequence. A new command is accepted as soon as
// the previous one has loaded its result, even while that result still waits
// for the downstream side; if it still waits when the next result is ready,
// the block holds in its final step. The list table's valid bits clear at
// reset; no clearing pass is needed.
module named_stack_queue_bank (
  input  logic         clk,
  input  logic         rst_n,
  nsqb_in_if.sink      in_ch,
  nsqb_out_if.source   out_ch
);

  nsqb_pkg::ctl_t                  ctl;
  logic [nsqb_pkg::DATA_W-1:0]     popped_bits;

  // The controller owns the handshakes and the step sequence.
  nsqb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  // The datapath holds the table, storage and every payload register.
  nsqb_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_cmd           (in_ch.cmd),
    .in_list_name     (in_ch.list_name),
    .in_kind          (in_ch.kind),
    .in_value         ($unsigned(in_ch.value)),
    .out_status       (out_ch.status),
    .out_popped_value (popped_bits),
    .out_popped_valid (out_ch.popped_valid)
  );

  assign out_ch.popped_value = $signed(popped_bits);

`ifndef ASSERT_OFF
  // Once a word is taken, the block runs its steps in fixed order.
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> ctl.lookup ##1 ctl.execute)
    else $error("command steps out of order");

  // No new command is taken while one is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready ##1 !in_ch.ready)
    else $error("command accepted while another is in flight");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // A popped element goes only with an ok status.
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.popped_valid) |-> (out_ch.status == nsqb_pkg::ST_OK))
    else $error("popped element with failing status");
`endif

endmodule
